// ===== rtl/core/eas_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder angle and speed package
// Shared types and constants for the encoder angle and speed calculator.
// ----------------------------------------------------------------------------
`default_nettype none
package eas_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ANGLE_OFFSET  = 3'd0;
  localparam logic [2:0] REG_POLE_PAIRS    = 3'd1;
  localparam logic [2:0] REG_BASE_RPM      = 3'd2;
  localparam logic [2:0] REG_COUNTS_REV    = 3'd3;
  localparam logic [2:0] REG_PERIOD_SCALER = 3'd4;

  localparam int unsigned DivW = 48;

  // Divider request from the sequencer
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [15:0]     den;
  } div_req_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quo;
    logic [15:0]     rem;
  } div_rsp_t;

endpackage : eas_pkg
`default_nettype wire

// ===== rtl/core/eas_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Shared unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module eas_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire eas_pkg::div_req_t req,
  output eas_pkg::div_rsp_t      rsp
);
  localparam int unsigned W = eas_pkg::DivW;

  logic [W-1:0]  quo_r, quo_nxt;
  logic [16:0]   rem_r, rem_nxt;
  logic [15:0]   den_r, den_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0]   trial;
  logic [17:0]   diff;

  // One shift and subtract step
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[15:0], quo_r[W-1]};
    diff     = {1'b0, trial} - {2'b00, den_r};
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r[16] || !diff[17]) begin
        rem_nxt = diff[16:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp = '{done: done_r, quo: quo_r, rem: rem_r[15:0]};

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider did not start");
endmodule : eas_div
`default_nettype wire

// ===== rtl/core/encoder_angle_speed_calc.sv =====
// ----------------------------------------------------------------------------
// Encoder angle and speed calculator
// Angle, electrical angle and two speed estimates from encoder updates.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// in_      slave      update: direction, counts, event flags, capture period
// out_     master     angles, index flag, fast and slow speeds
// cfg_     write      offset, pole pairs, base rpm, counts per rev, scaler
//
// One update runs from acceptance to out_tvalid through two to five passes of
// the shared 48-step restoring divider, up to two rpm products and the result
// register.
// rst_n is synchronous; registers take their documented reset values.
// in_tready is low while an update is in work or its result is not taken,
// so the next transaction can be taken the cycle after the result is accepted.
`default_nettype none
module encoder_angle_speed_calc #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // dir_forward, position_count, index_latched, unit_timeout,
  // latched_position, unit_pos_event, capture_overflow, capture_period, pad
  input  wire logic [71:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mech_angle, elec_angle, index_synced, fast_speed_pu, fast_speed_rpm,
  // slow_speed_pu, slow_speed_rpm, pad
  output logic [103:0]     out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int unsigned W  = eas_pkg::DivW;
  localparam int unsigned FW = FRACTION_BITS + 2;
  localparam int unsigned PW = FRACTION_BITS + 17;
  localparam logic [W-1:0] ONE = W'(1) << FRACTION_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_MOD  = 8'b00000010, S_MECH = 8'b00000100,
    S_LMOD = 8'b00001000, S_FRAC = 8'b00010000, S_SLOW = 8'b00100000,
    S_RPM  = 8'b01000000, S_OUT  = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] off_r, base_r, cpr_r, scl_r;
  logic [5:0]  pp_r;
  logic        prod_vld_r;

  // Held state
  logic [FRACTION_BITS-1:0] prev_r;
  logic        idx_r;
  logic [17:0] fpu_r;
  logic [16:0] frpm_r, spu_r, srpm_r;
  logic [14:0] mech_r, elec_r;

  // Latched input item
  logic        fwd_r, tmo_r, upe_r, ovf_r;
  logic [15:0] raw_r, per_r;
  logic [31:0] lat_r;
  logic        rpm_slow_r; // which rpm product is in work
  logic        issued_r;
  logic [FW-1:0] fd_r;      // fast difference, signed
  logic [FRACTION_BITS:0] spd_r;
  logic        ovalid_r;

  eas_pkg::div_req_t req;
  eas_pkg::div_rsp_t rsp;
  eas_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // Product of base rpm and a magnitude, one multiply in a register stage
  logic [FRACTION_BITS:0] mag;
  logic [FRACTION_BITS+16:0] prod_r;
  logic [16:0] rpm_v;
  logic [FW-1:0] fneg;
  assign fneg = -fd_r;
  assign mag  = rpm_slow_r ? spd_r :
                (fd_r[FW-1] ? fneg[FRACTION_BITS:0] : fd_r[FRACTION_BITS:0]);
  assign rpm_v = 17'(prod_r >> FRACTION_BITS);

  // With zero counts per revolution the new fraction is taken as zero
  logic [FW-1:0] nf, of, dcalc, onef;
  logic [W-1:0]  sq;
  assign nf   = (cpr_r == 16'd0) ? '0 : FW'(rsp.quo);
  assign of   = FW'(prev_r);
  assign onef = FW'(ONE);
  always_comb begin
    if (!fwd_r) dcalc = (nf > of) ? (nf - onef - of) : (nf - of);
    else        dcalc = (nf < of) ? (onef + nf - of) : (nf - of);
    sq = (rsp.quo > ONE) ? ONE : rsp.quo;
  end

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    req       = '0;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_MOD;
      S_MOD: begin
        if (!issued_r) begin
          req = '{1'b1, W'(raw_r), cpr_r};
        end else if (rsp.done) begin
          state_nxt = S_MECH;
        end
      end
      S_MECH: begin
        if (!issued_r) req = '{1'b1, W'(rsp.rem) * W'(32767), cpr_r};
        else if (rsp.done) state_nxt = tmo_r ? S_LMOD : (upe_r ? S_SLOW : S_OUT);
      end
      S_LMOD: begin
        if (!issued_r) req = '{1'b1, W'(lat_r), cpr_r};
        else if (rsp.done) state_nxt = S_FRAC;
      end
      S_FRAC: begin
        if (!issued_r) req = '{1'b1, W'(rsp.rem) << FRACTION_BITS, cpr_r};
        else if (rsp.done) state_nxt = S_RPM;
      end
      S_SLOW: begin
        if (!issued_r) req = '{1'b1, W'(scl_r) << FRACTION_BITS,
                               ovf_r ? 16'hFFFF : per_r};
        else if (rsp.done) state_nxt = S_RPM;
      end
      S_RPM: begin
        if (prod_vld_r) state_nxt = (!rpm_slow_r && upe_r) ? S_SLOW : S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fwd_r <= in_tdata[0];
      raw_r <= in_tdata[16:1] + off_r;
      tmo_r <= in_tdata[18];
      lat_r <= in_tdata[50:19];
      upe_r <= in_tdata[51];
      ovf_r <= in_tdata[52];
      per_r <= in_tdata[68:53];
    end
    prod_r <= PW'(mag) * PW'(base_r);
    if (state_r == S_MECH && rsp.done) begin
      mech_r <= (cpr_r == 16'd0) ? 15'd0 : rsp.quo[14:0];
      elec_r <= 15'(((cpr_r == 16'd0) ? 21'd0 : 21'(rsp.quo[14:0])) * 21'(pp_r));
    end
    if (state_r == S_FRAC && rsp.done) begin
      fd_r <= dcalc;
    end
    if (state_r == S_SLOW && rsp.done) begin
      spd_r <= (!ovf_r && per_r == 16'd0) ? ONE[FRACTION_BITS:0] : sq[FRACTION_BITS:0];
    end
    if (!rst_n) begin
      state_r <= S_IDLE; issued_r <= 1'b0; prod_vld_r <= 1'b0; ovalid_r <= 1'b0;
      off_r <= '0; pp_r <= 6'd1; base_r <= 16'd3000; cpr_r <= 16'd4000;
      scl_r <= 16'd1; prev_r <= '0; idx_r <= 1'b0;
      fpu_r <= '0; frpm_r <= '0; spu_r <= '0; srpm_r <= '0; rpm_slow_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      issued_r <= (state_nxt == state_r) && (req.start || issued_r);
      prod_vld_r <= (state_r == S_RPM) && !prod_vld_r;
      if (cfg_we) begin
        case (cfg_index)
          eas_pkg::REG_ANGLE_OFFSET:  off_r  <= cfg_data;
          eas_pkg::REG_POLE_PAIRS:    pp_r   <= cfg_data[5:0];
          eas_pkg::REG_BASE_RPM:      base_r <= cfg_data;
          eas_pkg::REG_COUNTS_REV:    cpr_r  <= cfg_data;
          eas_pkg::REG_PERIOD_SCALER: scl_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata[17]) idx_r <= 1'b1;
        rpm_slow_r <= 1'b0;
      end
      if (state_r == S_FRAC && rsp.done) begin
        prev_r <= (cpr_r == 16'd0) ? '0 : FRACTION_BITS'(rsp.quo);
        rpm_slow_r <= 1'b0;
      end
      if (state_r == S_SLOW && rsp.done) rpm_slow_r <= 1'b1;
      if (state_r == S_RPM && prod_vld_r) begin
        if (rpm_slow_r) begin
          spu_r  <= 17'(spd_r);
          srpm_r <= fwd_r ? rpm_v : -rpm_v;
        end else begin
          fpu_r  <= 18'($signed(fd_r));
          frpm_r <= fd_r[FW-1] ? -rpm_v : rpm_v;
        end
      end
      if (state_r == S_OUT) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'b0, srpm_r, spu_r, frpm_r, fpu_r, idx_r, elec_r, mech_r};

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready while busy");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> out_tvalid) else $error("result not shown");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result moved");
endmodule : encoder_angle_speed_calc
`default_nettype wire
